[hdl/ltsv_stream_parser_macros.svh]
// Assertion helpers for the LTSV stream parser.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef LTSV_STREAM_PARSER_MACROS_SVH
`define LTSV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication.
`define LTSVP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LTSVP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ltsvp_pkg.sv]
package ltsvp_pkg;

    localparam int LTSVP_MAX_FIELDS    = 16;
    localparam int LTSVP_MAX_LABEL_LEN = 32;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5a;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7a;

    typedef enum logic [2:0] {
        PH_REC_START,
        PH_AFTER_CR,
        PH_FIELD_START,
        PH_LABEL,
        PH_VALUE,
        PH_HALT
    } t_phase;

    typedef enum logic [2:0] {
        KIND_LABEL,
        KIND_COLON,
        KIND_VALUE,
        KIND_TAB,
        KIND_REC_END,
        KIND_SKIP_LF,
        KIND_IGNORED,
        KIND_END
    } t_kind;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_STOP,
        ST_FAIL,
        ST_OK
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_CHAR,
        ERR_NO_COLON,
        ERR_DUPLICATE,
        ERR_TOO_LONG,
        ERR_TOO_MANY
    } t_err;

    // Broadcast from the parser control to every label cell.
    typedef struct packed {
        logic [7:0] data;    // current word
        logic       take;    // word is appended to the open label
        logic       start;   // word is the first of a new label
        logic       commit;  // open label closes with its value
    } t_cell_ctl;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] field_index;
        t_status    status;
        t_err       error_code;
    } t_result;

    function automatic logic is_label_char(input logic [7:0] b);
        return (b >= CH_DIG_LO && b <= CH_DIG_HI) || (b >= CH_UC_LO && b <= CH_UC_HI) ||
               (b >= CH_LC_LO && b <= CH_LC_HI) || b == CH_UNDER || b == CH_DOT ||
               b == CH_DASH;
    endfunction

    function automatic logic is_line_end(input logic [7:0] b);
        return b == CH_CR || b == CH_LF;
    endfunction

endpackage

[hdl/ltsvp_cell.sv]
module ltsvp_cell import ltsvp_pkg::*; #(
    parameter int MAX_FIELDS    = LTSVP_MAX_FIELDS,
    parameter int MAX_LABEL_LEN = LTSVP_MAX_LABEL_LEN,
    parameter int CELL_IDX      = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  t_cell_ctl                              i_ctl,
    input  logic [$clog2(MAX_FIELDS + 1)-1:0]      i_field_count,
    input  logic [$clog2(MAX_LABEL_LEN + 1)-1:0]   i_label_length,
    input  logic [$clog2(MAX_LABEL_LEN + 1)-1:0]   i_rd_pos,
    input  logic                                   i_hit,
    output logic                                   o_hit
);

    localparam int FCW = $clog2(MAX_FIELDS + 1);
    localparam int LLW = $clog2(MAX_LABEL_LEN + 1);
    localparam int AW  = (MAX_LABEL_LEN > 1) ? $clog2(MAX_LABEL_LEN) : 1;

    logic [7:0]     r_mem [MAX_LABEL_LEN];
    logic [7:0]     r_rd;
    logic [LLW-1:0] r_len;
    logic           r_match;
    logic           n_match;
    logic           sel;
    logic           active;
    logic           mismatch;
    logic [LLW-1:0] pos;

    assign sel    = (i_field_count == FCW'(CELL_IDX));
    assign active = (FCW'(CELL_IDX) < i_field_count);
    assign pos    = i_ctl.start ? '0 : i_label_length;

    // Label bytes of this field; the byte for the next compare is read ahead into a register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && sel) begin
            r_mem[pos[AW-1:0]] <= i_ctl.data;
        end
        r_rd <= r_mem[i_rd_pos[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && sel) begin
            r_len <= i_label_length;
        end
    end

    assign mismatch = (r_len <= pos) || (r_rd != i_ctl.data);
    assign n_match  = (i_ctl.start | r_match) & ~mismatch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else if (i_ctl.take) begin
            r_match <= n_match;
        end
    end

    // Pass the duplicate flag down the row.
    assign o_hit = i_hit | (active & r_match & (r_len == i_label_length));

endmodule

[hdl/ltsv_stream_parser.sv]
// LTSV stream parser.
// Input channel (i_in_valid / o_in_ready) carries one word per item: a text byte
// on i_byte_req and an end flag on i_end_of_input. A NUL byte or the end flag
// closes the text. Every accepted word gives exactly one result word on the
// output channel (o_out_valid / i_out_ready): its class, the field index of the
// current record, and the run status and error code after that byte.
// The result is registered into the output queue on acceptance and offered once
// earlier results drain. Throughput: one word per cycle while there is room.
// Each label cell compares the incoming byte against a byte of its stored label
// prefetched into a register, so all fields compare their labels in parallel.
// Reset clears the control state and the output queue; stored labels are not
// cleared because only labels written in the current record are compared.
// A two-entry output queue takes the next word while a result waits; when the
// receiver stalls and both entries are held, o_in_ready drops until it drains.
// After a stop or failure every byte is ignored until the end of text, which
// reports the final status and returns the parser to record start.
`include "ltsv_stream_parser_macros.svh"

module ltsv_stream_parser import ltsvp_pkg::*; #(
    parameter int MAX_FIELDS    = LTSVP_MAX_FIELDS,
    parameter int MAX_LABEL_LEN = LTSVP_MAX_LABEL_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_req,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [3:0] o_field_index,
    output logic [1:0] o_status,
    output logic [2:0] o_error_code
);

    localparam int FCW = $clog2(MAX_FIELDS + 1);
    localparam int LLW = $clog2(MAX_LABEL_LEN + 1);

    // Parser state
    t_phase         r_phase,  n_phase;
    t_status        r_status, n_status;
    t_err           r_err,    n_err;
    logic [FCW-1:0] r_fcnt,   n_fcnt;
    logic [LLW-1:0] r_llen,   n_llen;
    logic           r_dup,    n_dup;

    // Output queue
    t_result        r_buf [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    logic           accept;
    logic           pop;
    logic           eot;
    logic           b_nl, b_lab, b_tab, b_colon, b_lf, b_cr;
    logic           fcnt_full;
    logic           llen_full;
    logic           hit_any;
    logic [LLW-1:0] rd_pos;
    t_result        res;
    t_cell_ctl      cell_ctl;
    logic           hit_chain [MAX_FIELDS + 1];

    assign accept = i_in_valid & o_in_ready;
    assign pop    = o_out_valid & i_out_ready;

    assign eot      = i_end_of_input || (i_byte_req == CH_NUL);
    assign b_nl     = is_line_end(i_byte_req);
    assign b_lab    = is_label_char(i_byte_req);
    assign b_tab    = (i_byte_req == CH_TAB);
    assign b_colon  = (i_byte_req == CH_COLON);
    assign b_lf     = (i_byte_req == CH_LF);
    assign b_cr     = (i_byte_req == CH_CR);

    assign fcnt_full = (r_fcnt >= FCW'(MAX_FIELDS));
    assign llen_full = (r_llen >= LLW'(MAX_LABEL_LEN));

    // Next state: advance only on an accepted word.
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_err    = r_err;
        n_fcnt   = r_fcnt;
        n_llen   = r_llen;
        n_dup    = r_dup;
        if (accept) begin
            if (eot) begin
                // End of text: back to record start, nothing kept.
                n_phase  = PH_REC_START;
                n_status = ST_RUN;
                n_err    = ERR_NONE;
                n_fcnt   = '0;
                n_llen   = '0;
                n_dup    = 1'b0;
            end else begin
                case (r_phase)
                    PH_REC_START, PH_AFTER_CR, PH_FIELD_START: begin
                        if (r_phase == PH_AFTER_CR && b_lf) begin
                            // Swallow the LF of a CR LF pair.
                            n_phase = PH_REC_START;
                        end else if (b_nl) begin
                            n_fcnt  = '0;
                            n_phase = b_cr ? PH_AFTER_CR : PH_REC_START;
                        end else if (!b_lab) begin
                            n_phase  = PH_HALT;
                            n_status = ST_FAIL;
                            n_err    = ERR_BAD_CHAR;
                        end else if (fcnt_full) begin
                            n_phase  = PH_HALT;
                            n_status = ST_FAIL;
                            n_err    = ERR_TOO_MANY;
                        end else begin
                            n_llen  = LLW'(1);
                            n_dup   = 1'b0;
                            n_phase = PH_LABEL;
                        end
                    end
                    PH_LABEL: begin
                        if (b_lab) begin
                            if (llen_full) begin
                                n_phase  = PH_HALT;
                                n_status = ST_FAIL;
                                n_err    = ERR_TOO_LONG;
                            end else begin
                                n_llen = r_llen + LLW'(1);
                            end
                        end else if (b_colon) begin
                            n_dup   = hit_any;
                            n_phase = PH_VALUE;
                        end else if (b_nl) begin
                            n_phase  = PH_HALT;
                            n_status = ST_STOP;
                            n_err    = ERR_NO_COLON;
                        end else begin
                            n_phase  = PH_HALT;
                            n_status = ST_FAIL;
                            n_err    = ERR_NO_COLON;
                        end
                    end
                    PH_VALUE: begin
                        if (b_tab || b_nl) begin
                            if (r_dup) begin
                                n_phase  = PH_HALT;
                                n_status = b_tab ? ST_FAIL : ST_STOP;
                                n_err    = ERR_DUPLICATE;
                            end else if (b_tab) begin
                                n_fcnt  = r_fcnt + FCW'(1);
                                n_phase = PH_FIELD_START;
                            end else begin
                                n_fcnt  = '0;
                                n_phase = b_cr ? PH_AFTER_CR : PH_REC_START;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Outputs: result word and the cell controls.
    always_comb begin
        res.kind        = KIND_IGNORED;
        res.field_index = 4'(r_fcnt);
        res.status      = n_status;
        res.error_code  = n_err;
        cell_ctl.data   = i_byte_req;
        cell_ctl.take   = 1'b0;
        cell_ctl.start  = 1'b0;
        cell_ctl.commit = 1'b0;
        if (eot) begin
            res.kind       = KIND_END;
            res.status     = r_status;
            res.error_code = r_err;
            if (r_status == ST_RUN) begin
                if (r_phase == PH_LABEL) begin
                    res.status     = ST_FAIL;
                    res.error_code = ERR_NO_COLON;
                end else if (r_phase == PH_VALUE && r_dup) begin
                    res.status     = ST_FAIL;
                    res.error_code = ERR_DUPLICATE;
                end else begin
                    res.status = ST_OK;
                end
            end
        end else begin
            case (r_phase)
                PH_REC_START, PH_AFTER_CR, PH_FIELD_START: begin
                    if (r_phase == PH_AFTER_CR && b_lf) begin
                        res.kind = KIND_SKIP_LF;
                    end else if (b_nl) begin
                        res.kind = KIND_REC_END;
                    end else if (b_lab && !fcnt_full) begin
                        res.kind       = KIND_LABEL;
                        cell_ctl.take  = accept;
                        cell_ctl.start = accept;
                    end
                end
                PH_LABEL: begin
                    if (b_lab && !llen_full) begin
                        res.kind      = KIND_LABEL;
                        cell_ctl.take = accept;
                    end else if (b_colon) begin
                        res.kind = KIND_COLON;
                    end
                end
                PH_VALUE: begin
                    if (b_tab || b_nl) begin
                        if (!r_dup) begin
                            res.kind        = b_tab ? KIND_TAB : KIND_REC_END;
                            cell_ctl.commit = accept;
                        end
                    end else begin
                        res.kind = KIND_VALUE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_REC_START;
            r_status <= ST_RUN;
            r_err    <= ERR_NONE;
            r_fcnt   <= '0;
            r_llen   <= '0;
            r_dup    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_err    <= n_err;
            r_fcnt   <= n_fcnt;
            r_llen   <= n_llen;
            r_dup    <= n_dup;
        end
    end

    // Prefetch address: the label position that the next word will compare.
    assign rd_pos = (n_phase == PH_LABEL) ? n_llen : '0;

    // Row of label cells, one per field of the record.
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_FIELDS; g++) begin : g_cell
        ltsvp_cell #(
            .MAX_FIELDS    (MAX_FIELDS),
            .MAX_LABEL_LEN (MAX_LABEL_LEN),
            .CELL_IDX      (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (cell_ctl),
            .i_field_count  (r_fcnt),
            .i_label_length (r_llen),
            .i_rd_pos       (rd_pos),
            .i_hit          (hit_chain[g]),
            .o_hit          (hit_chain[g + 1])
        );
    end

    assign hit_any = hit_chain[MAX_FIELDS];

    // Two-entry output queue.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(accept) - 2'(pop);
        end
    end

    assign o_in_ready    = (r_count != 2'd2);
    assign o_out_valid   = (r_count != 2'd0);
    assign o_kind        = r_buf[r_rd_ptr].kind;
    assign o_field_index = r_buf[r_rd_ptr].field_index;
    assign o_status      = r_buf[r_rd_ptr].status;
    assign o_error_code  = r_buf[r_rd_ptr].error_code;

    `LTSVP_ASSERT_IMP(a_halt_ignores, accept && !eot && r_phase == PH_HALT, res.kind == KIND_IGNORED, "byte after halt not ignored")
    `LTSVP_ASSERT_NXT(a_eot_restart, accept && eot, r_phase == PH_REC_START && r_fcnt == '0 && r_status == ST_RUN, "end of text did not restart")
    `LTSVP_ASSERT_IMP(a_run_matches_phase, 1'b1, (r_status == ST_RUN) == (r_phase != PH_HALT), "run status and phase disagree")
    `LTSVP_ASSERT_IMP(a_label_len_range, r_phase == PH_LABEL, r_llen != '0 && r_llen <= LLW'(MAX_LABEL_LEN), "open label length out of range")

endmodule
